// ===== rtl/core/wmrs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmrs_pkg
// Shared types and constants of the windowed minimum range selector.
// ----------------------------------------------------------------------------
package wmrs_pkg;

	localparam int COORD_W = 16;
	localparam int RANGE_W = 32;
	localparam int ID_W    = 2;

	// squared range that no real point reaches ("infinite")
	localparam logic [RANGE_W-1:0] RANGE_INF = '1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQR,
		ST_WRITE,
		ST_SCAN,
		ST_DRAIN,
		ST_PICK,
		ST_DONE
	} state_t;

	// control decoded from the sequencer state
	typedef struct packed {
		logic s_ready;
		logic sq_start;
		logic ram_we;
		logic ram_re;
		logic pick;
		logic out_load;
	} ctrl_t;

endpackage

// ===== rtl/core/wmrs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmrs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module wmrs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 150,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== rtl/core/wmrs_sqr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wmrs_sqr
// Two-stage squared range: |x|^2 and |y|^2 in stage one, their sum in stage two.
// ----------------------------------------------------------------------------
module wmrs_sqr (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic signed [wmrs_pkg::COORD_W-1:0]  x,
	input  logic signed [wmrs_pkg::COORD_W-1:0]  y,
	output logic                                 done,
	output logic        [wmrs_pkg::RANGE_W-1:0]  range
);

	localparam int CW = wmrs_pkg::COORD_W;
	localparam int RW = wmrs_pkg::RANGE_W;

	logic [CW-1:0] ax, ay;
	logic [RW-1:0] sq_x_s1, sq_y_s1;
	logic          vld_s1, vld_s2;
	logic [RW-1:0] range_s2;

	// magnitudes; -32768 maps to 32768 as unsigned
	always_comb begin
		ax = x[CW-1] ? CW'(-x) : CW'(x);
		ay = y[CW-1] ? CW'(-y) : CW'(y);
	end

	// valid pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else begin
			vld_s1 <= start;
			vld_s2 <= vld_s1;
		end
	end

	// products, then sum (at most 2^31, no overflow)
	always_ff @(posedge clk) begin
		sq_x_s1  <= RW'(ax) * RW'(ax);
		sq_y_s1  <= RW'(ay) * RW'(ay);
		range_s2 <= sq_x_s1 + sq_y_s1;
	end

	assign done  = vld_s2;
	assign range = range_s2;

endmodule

// ===== rtl/core/windowed_min_range_selector.sv =====
`timescale 1ns / 1ps
// A request with a valid id passes ST_SQR, ST_WRITE, ST_SCAN, ST_DRAIN, ST_PICK
// and ST_DONE into the output register; an out-of-range id goes from ST_IDLE
// straight to ST_DONE. The minimum scan reads the track's window one RAM entry per
// cycle. s_tready is high only in ST_IDLE, so a new item is accepted only after the
// last one has left ST_DONE. A stalled result holds the sequencer in ST_DONE.
// Reset: asynchronous; takes effect at once, no clearing pass. Unwritten entries masked.
// ----------------------------------------------------------------------------
// windowed_min_range_selector
// Per-track sliding window of squared ranges in RAM; the point whose range is
// the window minimum becomes the track's selected point. Output is the midpoint
// of the selected points of tracks 0 and 1 plus the window minimum.
// ----------------------------------------------------------------------------
module windowed_min_range_selector #(
	parameter int WINDOW_DEPTH = 50,
	parameter int TRACK_COUNT  = 3
) (
	input  logic        clk,
	input  logic        arst_n,
	// input request
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [15:0] x_pos, [31:16] y_pos
	input  logic [1:0]  s_tuser,   // [1:0] track_id
	// result request
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // [15:0] mid_x, [31:16] mid_y, [63:32] window_min
	output logic [1:0]  m_tuser    // [0] chosen, [1] bad_id
);

	localparam int CW   = wmrs_pkg::COORD_W;
	localparam int RW   = wmrs_pkg::RANGE_W;
	localparam int MEMD = TRACK_COUNT * WINDOW_DEPTH;
	localparam int AW   = (MEMD > 1) ? $clog2(MEMD) : 1;
	localparam int IW   = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int TW   = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(WINDOW_DEPTH - 1);

	wmrs_pkg::state_t state_q, state_d;
	wmrs_pkg::ctrl_t  ctrl;

	logic                 accept;
	logic                 id_ok;
	logic [TW-1:0]        tid_q;
	logic [AW-1:0]        base_q;
	logic                 bad_q;
	logic signed [CW-1:0] x_q, y_q;
	logic                 sq_pending_q;

	logic [IW-1:0]        slot_q [TRACK_COUNT];
	logic                 wrap_q [TRACK_COUNT];
	logic [IW-1:0]        cur_slot_q;
	logic                 cur_wrap_q;

	logic [IW-1:0]        rd_idx_q;
	logic                 cmp_vld_s1;
	logic [IW-1:0]        cmp_idx_s1;
	logic [RW-1:0]        wmin_q;
	logic                 chosen_q;

	logic                 sq_done;
	logic [RW-1:0]        sq_range;
	logic [RW-1:0]        ram_rdata;
	logic [AW-1:0]        ram_waddr, ram_raddr;

	logic signed [CW-1:0] pick_x_q [2];
	logic signed [CW-1:0] pick_y_q [2];
	logic signed [CW:0]   sum_x, sum_y;

	logic                 m_tvalid_q;
	logic [63:0]          m_tdata_q;
	logic [1:0]           m_tuser_q;

	assign accept = s_tvalid && s_tready;
	assign id_ok  = 32'(s_tuser) < 32'(TRACK_COUNT);

	// squared range unit
	wmrs_sqr u_sqr (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.sq_start),
		.x      (x_q),
		.y      (y_q),
		.done   (sq_done),
		.range  (sq_range)
	);

	// range history, one ring of WINDOW_DEPTH entries per track
	assign ram_waddr = base_q + AW'(cur_slot_q);
	assign ram_raddr = base_q + AW'(rd_idx_q);

	wmrs_ram #(
		.WIDTH (RW),
		.DEPTH (MEMD)
	) u_hist (
		.clk   (clk),
		.we    (ctrl.ram_we),
		.waddr (ram_waddr),
		.wdata (sq_range),
		.re    (ctrl.ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			wmrs_pkg::ST_IDLE: begin
				if (s_tvalid) state_d = id_ok ? wmrs_pkg::ST_SQR : wmrs_pkg::ST_DONE;
			end
			wmrs_pkg::ST_SQR: begin
				if (sq_done) state_d = wmrs_pkg::ST_WRITE;
			end
			wmrs_pkg::ST_WRITE: state_d = wmrs_pkg::ST_SCAN;
			wmrs_pkg::ST_SCAN: begin
				if (rd_idx_q == LAST_IDX) state_d = wmrs_pkg::ST_DRAIN;
			end
			wmrs_pkg::ST_DRAIN: state_d = wmrs_pkg::ST_PICK;
			wmrs_pkg::ST_PICK:  state_d = wmrs_pkg::ST_DONE;
			wmrs_pkg::ST_DONE: begin
				if (!m_tvalid_q || m_tready) state_d = wmrs_pkg::ST_IDLE;
			end
			default: state_d = wmrs_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		ctrl = '0;
		unique case (state_q)
			wmrs_pkg::ST_IDLE:  ctrl.s_ready  = 1'b1;
			wmrs_pkg::ST_SQR:   ctrl.sq_start = 1'b0;
			wmrs_pkg::ST_WRITE: ctrl.ram_we   = 1'b1;
			wmrs_pkg::ST_SCAN:  ctrl.ram_re   = 1'b1;
			wmrs_pkg::ST_DRAIN: ctrl.ram_re   = 1'b0;
			wmrs_pkg::ST_PICK:  ctrl.pick     = 1'b1;
			wmrs_pkg::ST_DONE:  ctrl.out_load = !m_tvalid_q || m_tready;
			default:            ctrl = '0;
		endcase
		// square starts the cycle after the request lands in x_q/y_q
		ctrl.sq_start = (state_q == wmrs_pkg::ST_SQR) && !sq_pending_q;
	end

	assign s_tready = ctrl.s_ready;

	// one start pulse per item into the square pipe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sq_pending_q <= 1'b0;
		end else if (state_q != wmrs_pkg::ST_SQR) begin
			sq_pending_q <= 1'b0;
		end else begin
			sq_pending_q <= 1'b1;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= wmrs_pkg::ST_IDLE;
			cmp_vld_s1 <= 1'b0;
			rd_idx_q   <= '0;
			for (int t = 0; t < TRACK_COUNT; t++) begin
				slot_q[t] <= '0;
				wrap_q[t] <= 1'b0;
			end
			for (int t = 0; t < 2; t++) begin
				pick_x_q[t] <= '0;
				pick_y_q[t] <= '0;
			end
		end else begin
			state_q    <= state_d;
			cmp_vld_s1 <= ctrl.ram_re;
			// advance this track's write slot
			if (ctrl.ram_we) begin
				rd_idx_q <= '0;
				if (cur_slot_q == LAST_IDX) begin
					slot_q[tid_q] <= '0;
					wrap_q[tid_q] <= 1'b1;
				end else begin
					slot_q[tid_q] <= cur_slot_q + 1'b1;
				end
			end else if (ctrl.ram_re) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			// new selected point for tracks 0 and 1 (others never reach the output)
			if (ctrl.pick && (sq_range == wmin_q)) begin
				if (32'(tid_q) == 0) begin
					pick_x_q[0] <= x_q;
					pick_y_q[0] <= y_q;
				end
				if (32'(tid_q) == 1) begin
					pick_x_q[1] <= x_q;
					pick_y_q[1] <= y_q;
				end
			end
		end
	end

	// item and scan payload
	always_ff @(posedge clk) begin
		if (accept) begin
			tid_q  <= TW'(s_tuser);
			base_q <= AW'(32'(s_tuser) * WINDOW_DEPTH);
			bad_q  <= !id_ok;
			x_q    <= s_tdata[15:0];
			y_q    <= s_tdata[31:16];
			wmin_q <= wmrs_pkg::RANGE_INF;
		end
		if (state_q == wmrs_pkg::ST_SQR) begin
			cur_slot_q <= slot_q[tid_q];
			cur_wrap_q <= wrap_q[tid_q];
		end
		cmp_idx_s1 <= rd_idx_q;
		// running minimum over entries written so far
		if (cmp_vld_s1 && (cur_wrap_q || (cmp_idx_s1 <= cur_slot_q))
				&& (ram_rdata < wmin_q)) begin
			wmin_q <= ram_rdata;
		end
		if (ctrl.pick) begin
			chosen_q <= (sq_range == wmin_q);
		end
	end

	// midpoint, arithmetic shift of the 17-bit sum
	always_comb begin
		sum_x = {pick_x_q[0][CW-1], pick_x_q[0]} + {pick_x_q[1][CW-1], pick_x_q[1]};
		sum_y = {pick_y_q[0][CW-1], pick_y_q[0]} + {pick_y_q[1][CW-1], pick_y_q[1]};
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (ctrl.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			m_tdata_q[15:0]  <= sum_x[CW:1];
			m_tdata_q[31:16] <= sum_y[CW:1];
			m_tdata_q[63:32] <= bad_q ? '0 : wmin_q;
			m_tuser_q[0]     <= !bad_q && chosen_q;
			m_tuser_q[1]     <= bad_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
